// ===== hdl/ptem_pkg.sv =====
// Package for the planar twist exponential map core.
// Holds the fixed-point constants, the CORDIC arctangent table and the pipeline payload types.
// No dependencies.
`timescale 1ns / 1ps

package ptem_pkg;

	localparam int DIV_W = 48;      // dividend magnitude width, also the number of divider steps
	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [33:0] MONE_Q30 = -34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
	localparam logic signed [31:0] TURN_SCALE = 32'sd683565276;
	localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
	localparam logic [15:0] LIMIT_RESET = 16'd655;

	// Payload travelling beside the CORDIC rotator.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0] mag;
		logic th_neg;
		logic taylor;
		logic signed [31:0] s_tay;
		logic signed [31:0] c_tay;
		logic fold_neg;
	} crd_pay_t;

	// Payload travelling beside the two dividers.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] cs;
		logic signed [31:0] sn;
		logic [31:0] mag;
		logic qs_neg;
		logic qc_neg;
		logic taylor;
		logic signed [31:0] s_tay;
		logic signed [31:0] c_tay;
	} div_pay_t;

	// Arctangent of 2^-i as a binary angle, 2^32 per turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/planar_twist_exponential_map_core.sv =====
// Planar twist exponential map core: fully pipelined SE(2) exponential for odometry.
// Depends on ptem_pkg for constants, the arctangent table and payload types.
`timescale 1ns / 1ps

// How to use this block.
// The input stream (s_axis) carries one twist per beat: body velocities, yaw rate and time
// step. The output stream (m_axis) returns one beat per input beat, in order, holding the
// translation in Q16.16 and the heading cosine and sine in Q2.30; tuser flags a clipped
// result. The configuration channel (cfg) writes the small-angle limit in Q16.16 radians,
// below which the Taylor forms replace the division; cfg_ready is always high and the
// register should only be written while no beat is in flight.
// An accepted input beat reaches its output beat through these pipeline stages in order:
// three entry stages (products, angle scaling, folding), one stage per CORDIC iteration,
// one stage to form the dividends, one stage per quotient bit of the two 48-bit restoring
// dividers that run side by side, then the quotient saturation, the four translation
// products and the final rounding stage, which is also the output register.
// Throughput is one beat per cycle while the receiver does not stall; each stage advances
// on its own whenever it is empty or its successor advances, so bubbles are squeezed out
// and a beat can enter while a finished result is still waiting at the output.
// When the receiver stalls, data stays in place and nothing is lost or repeated; input is
// refused only once every stage holds a beat. Reset empties the pipeline and sets the
// small-angle limit to 655.

module planar_twist_exponential_map_core #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vel_x[31:0], vel_y[63:32], yaw_rate[95:64], time_step[111:96]
	input  logic [111:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// move_x[31:0], move_y[63:32], heading_cos[95:64], heading_sin[127:96]
	output logic [127:0] m_axis_tdata,
	// saturated[0]
	output logic [0:0] m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import ptem_pkg::*;

	logic [15:0] limit_q;

	// Stage handshake: a stage advances if it is empty or its successor advances.
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
	logic [CORDIC_STAGES-1:0] crd_adv;
	logic [DIV_W-1:0] div_adv;

	// Stage 1: displacements.
	logic v_s1;
	logic signed [31:0] x_s1, y_s1, th_s1;
	// Stage 2: angle product, magnitude and square.
	logic v_s2;
	logic signed [31:0] x_s2, y_s2, th_s2;
	logic signed [63:0] ang_prod_s2;
	logic [31:0] mag_s2;
	logic [31:0] sq_s2;
	// Stage 3: folded angle, Taylor terms.
	logic v_s3;
	logic signed [33:0] z_s3;
	logic [60:0] rp_s3;
	crd_pay_t pay_s3;
	// CORDIC stages.
	logic [CORDIC_STAGES-1:0] crd_v_sc;
	logic signed [33:0] crd_x_sc [CORDIC_STAGES];
	logic signed [33:0] crd_y_sc [CORDIC_STAGES];
	logic signed [33:0] crd_z_sc [CORDIC_STAGES];
	crd_pay_t crd_p_sc [CORDIC_STAGES];
	// Stage 4: dividends.
	logic v_s4;
	logic [DIV_W-1:0] dvd_s_s4, dvd_c_s4;
	div_pay_t pay_s4;
	// Divider stages.
	logic [DIV_W-1:0] div_v_sd;
	logic [31:0] rs_sd [DIV_W];
	logic [31:0] rc_sd [DIV_W];
	logic [DIV_W-1:0] qs_sd [DIV_W];
	logic [DIV_W-1:0] qc_sd [DIV_W];
	div_pay_t div_p_sd [DIV_W];
	// Stage 5: s and c selected.
	logic v_s5;
	logic signed [31:0] x_s5, y_s5, s_s5, c_s5, cs_s5, sn_s5;
	logic sat_s5;
	// Stage 6: products.
	logic v_s6;
	logic signed [63:0] pxs_s6, pyc_s6, pxc_s6, pys_s6;
	logic signed [31:0] cs_s6, sn_s6;
	logic sat_s6;
	// Stage 7: output register.
	logic v_s7;
	logic signed [31:0] mx_s7, my_s7, cs_s7, sn_s7;
	logic sat_s7;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	assign adv7 = !v_s7 || m_axis_tready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || div_adv[0];
	assign adv3 = !v_s3 || crd_adv[0];
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	// Stage 1: x, y and theta as round-half-up of velocity times time step.
	logic signed [48:0] px1, py1, pt1;
	always_comb begin
		px1 = $signed(s_axis_tdata[31:0]) * $signed({1'b0, s_axis_tdata[111:96]})
			+ 49'sd32768;
		py1 = $signed(s_axis_tdata[63:32]) * $signed({1'b0, s_axis_tdata[111:96]})
			+ 49'sd32768;
		pt1 = $signed(s_axis_tdata[95:64]) * $signed({1'b0, s_axis_tdata[111:96]})
			+ 49'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s1 <= px1[47:16];
			y_s1 <= py1[47:16];
			th_s1 <= pt1[47:16];
		end
	end

	// Stage 2: scale theta to a binary angle; magnitude and its square for the Taylor form.
	logic [31:0] mag1;
	assign mag1 = th_s1[31] ? 32'(-th_s1) : 32'(th_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			th_s2 <= th_s1;
			ang_prod_s2 <= th_s1 * TURN_SCALE;
			mag_s2 <= mag1;
			sq_s2 <= mag1[15:0] * mag1[15:0];
		end
	end

	// Stage 3: fold the angle into +-quarter turn and start theta^2/24 by a reciprocal.
	logic signed [63:0] ang_r;
	logic signed [33:0] z_raw, z_fold;
	logic fold2;
	crd_pay_t pay2;
	always_comb begin
		ang_r = ang_prod_s2 + 64'sd32768;
		z_raw = {{2{ang_r[47]}}, ang_r[47:16]};
		fold2 = 1'b0;
		z_fold = z_raw;
		if (z_raw > ONE_Q30) begin
			z_fold = z_raw - HALF_TURN;
			fold2 = 1'b1;
		end else if (z_raw < MONE_Q30) begin
			z_fold = z_raw + HALF_TURN;
			fold2 = 1'b1;
		end
		pay2.x = x_s2;
		pay2.y = y_s2;
		pay2.mag = mag_s2;
		pay2.th_neg = th_s2[31];
		pay2.taylor = (th_s2 == 32'sd0) || (mag_s2 < {16'd0, limit_q});
		pay2.s_tay = 32'sd0;
		pay2.c_tay = {th_s2[18:0], 13'd0};
		pay2.fold_neg = fold2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			z_s3 <= z_fold;
			rp_s3 <= {32'd0, sq_s2[31:3]} * {29'd0, RECIP3};
			pay_s3 <= pay2;
		end
	end

	// CORDIC rotator, one iteration per stage.
	crd_pay_t pay_c0;
	always_comb begin
		pay_c0 = pay_s3;
		pay_c0.s_tay = 32'(ONE_Q30) - {4'd0, rp_s3[60:33]};
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_crd
		logic signed [33:0] xi, yi, zi, xo, yo, zo, at;
		logic vi;
		crd_pay_t pi;

		if (k == 0) begin : g_first
			assign xi = INV_GAIN;
			assign yi = 34'sd0;
			assign zi = z_s3;
			assign vi = v_s3;
			assign pi = pay_c0;
		end else begin : g_next
			assign xi = crd_x_sc[k-1];
			assign yi = crd_y_sc[k-1];
			assign zi = crd_z_sc[k-1];
			assign vi = crd_v_sc[k-1];
			assign pi = crd_p_sc[k-1];
		end

		if (k == CORDIC_STAGES - 1) begin : g_last
			assign crd_adv[k] = !crd_v_sc[k] || adv4;
		end else begin : g_mid
			assign crd_adv[k] = !crd_v_sc[k] || crd_adv[k+1];
		end

		assign at = $signed({2'b00, atan_turn(5'(k))});

		always_comb begin
			if (!zi[33]) begin
				xo = xi - (yi >>> k);
				yo = yi + (xi >>> k);
				zo = zi - at;
			end else begin
				xo = xi + (yi >>> k);
				yo = yi - (xi >>> k);
				zo = zi + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				crd_v_sc[k] <= 1'b0;
			end else if (crd_adv[k]) begin
				crd_v_sc[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (crd_adv[k]) begin
				crd_x_sc[k] <= xo;
				crd_y_sc[k] <= yo;
				crd_z_sc[k] <= zo;
				crd_p_sc[k] <= pi;
			end
		end
	end

	// Stage 4: undo the fold, clamp to unit, form the dividend magnitudes.
	crd_pay_t pl;
	logic signed [33:0] xn, yn, xc, yc;
	logic signed [33:0] one_m_cos;
	logic [31:0] sn_mag;
	div_pay_t pay3;
	always_comb begin
		pl = crd_p_sc[CORDIC_STAGES-1];
		xn = pl.fold_neg ? -crd_x_sc[CORDIC_STAGES-1] : crd_x_sc[CORDIC_STAGES-1];
		yn = pl.fold_neg ? -crd_y_sc[CORDIC_STAGES-1] : crd_y_sc[CORDIC_STAGES-1];
		xc = (xn > ONE_Q30) ? ONE_Q30 : ((xn < MONE_Q30) ? MONE_Q30 : xn);
		yc = (yn > ONE_Q30) ? ONE_Q30 : ((yn < MONE_Q30) ? MONE_Q30 : yn);
		one_m_cos = ONE_Q30 - xc;
		sn_mag = yc[33] ? 32'(-yc) : 32'(yc);
		pay3.x = pl.x;
		pay3.y = pl.y;
		pay3.cs = xc[31:0];
		pay3.sn = yc[31:0];
		pay3.mag = pl.mag;
		pay3.qs_neg = yc[33] ^ pl.th_neg;
		pay3.qc_neg = pl.th_neg;
		pay3.taylor = pl.taylor;
		pay3.s_tay = pl.s_tay;
		pay3.c_tay = pl.c_tay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= crd_v_sc[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			dvd_s_s4 <= {sn_mag, 16'd0};
			dvd_c_s4 <= {one_m_cos[31:0], 16'd0};
			pay_s4 <= pay3;
		end
	end

	// Two restoring dividers in lockstep, one quotient bit per stage. The dividend shifts
	// out of the top of the q register while quotient bits shift in at the bottom.
	for (genvar j = 0; j < DIV_W; j++) begin : g_div
		logic [31:0] rsi, rci;
		logic [DIV_W-1:0] qsi, qci;
		logic vi;
		div_pay_t pi;
		logic [32:0] ts, tc;
		logic ges, gec;

		if (j == 0) begin : g_first
			assign rsi = 32'd0;
			assign rci = 32'd0;
			assign qsi = dvd_s_s4;
			assign qci = dvd_c_s4;
			assign vi = v_s4;
			assign pi = pay_s4;
		end else begin : g_next
			assign rsi = rs_sd[j-1];
			assign rci = rc_sd[j-1];
			assign qsi = qs_sd[j-1];
			assign qci = qc_sd[j-1];
			assign vi = div_v_sd[j-1];
			assign pi = div_p_sd[j-1];
		end

		if (j == DIV_W - 1) begin : g_last
			assign div_adv[j] = !div_v_sd[j] || adv5;
		end else begin : g_mid
			assign div_adv[j] = !div_v_sd[j] || div_adv[j+1];
		end

		assign ts = {rsi, qsi[DIV_W-1]};
		assign tc = {rci, qci[DIV_W-1]};
		assign ges = ts >= {1'b0, pi.mag};
		assign gec = tc >= {1'b0, pi.mag};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_sd[j] <= 1'b0;
			end else if (div_adv[j]) begin
				div_v_sd[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (div_adv[j]) begin
				rs_sd[j] <= ges ? 32'(ts - {1'b0, pi.mag}) : ts[31:0];
				rc_sd[j] <= gec ? 32'(tc - {1'b0, pi.mag}) : tc[31:0];
				qs_sd[j] <= {qsi[DIV_W-2:0], ges};
				qc_sd[j] <= {qci[DIV_W-2:0], gec};
				div_p_sd[j] <= pi;
			end
		end
	end

	// Stage 5: sign the quotients, saturate them, or take the Taylor forms.
	function automatic logic [32:0] sat_quot(input logic [DIV_W-1:0] q, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (q > 48'h0000_8000_0000) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, 32'(-q[31:0])};
			end
		end else begin
			if (q > 48'h0000_7FFF_FFFF) begin
				r = {1'b1, 32'h7FFF_FFFF};
			end else begin
				r = {1'b0, q[31:0]};
			end
		end
		return r;
	endfunction

	div_pay_t pd;
	logic [32:0] sq5, cq5;
	assign pd = div_p_sd[DIV_W-1];
	assign sq5 = sat_quot(qs_sd[DIV_W-1], pd.qs_neg);
	assign cq5 = sat_quot(qc_sd[DIV_W-1], pd.qc_neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv5) begin
			v_s5 <= div_v_sd[DIV_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			x_s5 <= pd.x;
			y_s5 <= pd.y;
			cs_s5 <= pd.cs;
			sn_s5 <= pd.sn;
			if (pd.taylor) begin
				s_s5 <= pd.s_tay;
				c_s5 <= pd.c_tay;
				sat_s5 <= 1'b0;
			end else begin
				s_s5 <= sq5[31:0];
				c_s5 <= cq5[31:0];
				sat_s5 <= sq5[32] | cq5[32];
			end
		end
	end

	// Stage 6: the four translation products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			pxs_s6 <= x_s5 * s_s5;
			pyc_s6 <= y_s5 * c_s5;
			pxc_s6 <= x_s5 * c_s5;
			pys_s6 <= y_s5 * s_s5;
			cs_s6 <= cs_s5;
			sn_s6 <= sn_s5;
			sat_s6 <= sat_s5;
		end
	end

	// Stage 7: combine, round half up to Q16.16 and saturate.
	logic signed [65:0] sum_x, sum_y;
	logic signed [35:0] sh_x, sh_y;
	logic ovx, ovy;
	logic signed [31:0] mx6, my6;
	always_comb begin
		sum_x = 66'(pxs_s6) - 66'(pyc_s6) + 66'sd536870912;
		sum_y = 66'(pxc_s6) + 66'(pys_s6) + 66'sd536870912;
		sh_x = sum_x[65:30];
		sh_y = sum_y[65:30];
		ovx = 1'b0;
		ovy = 1'b0;
		mx6 = sh_x[31:0];
		my6 = sh_y[31:0];
		if (sh_x > 36'sd2147483647) begin
			mx6 = 32'sh7FFF_FFFF;
			ovx = 1'b1;
		end else if (sh_x < -36'sd2147483648) begin
			mx6 = 32'sh8000_0000;
			ovx = 1'b1;
		end
		if (sh_y > 36'sd2147483647) begin
			my6 = 32'sh7FFF_FFFF;
			ovy = 1'b1;
		end else if (sh_y < -36'sd2147483648) begin
			my6 = 32'sh8000_0000;
			ovy = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			mx_s7 <= mx6;
			my_s7 <= my6;
			cs_s7 <= cs_s6;
			sn_s7 <= sn_s6;
			sat_s7 <= sat_s6 | ovx | ovy;
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata = {sn_s7, cs_s7, my_s7, mx_s7};
	assign m_axis_tuser = sat_s7;

endmodule
